// File: rtl/core/aes_pkg.sv
// AES-128 CFB8 shared types, constants and round functions.
// No dependencies.
package aes_pkg;
  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW = 2'd1,
    CFG_ENABLE = 2'd2
  } cfg_idx_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // state byte i sits in bits 127-8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8*(c*4+r) -: 8] = sbox(s[127 - 8*((((c+r)&3)*4)+r) -: 8]);
    return t;
  endfunction

  function automatic logic [127:0] mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 8] = a0 ^ al ^ xt(a0 ^ a1);
      t[119 - 32*c -: 8] = a1 ^ al ^ xt(a1 ^ a2);
      t[111 - 32*c -: 8] = a2 ^ al ^ xt(a2 ^ a3);
      t[103 - 32*c -: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    return t;
  endfunction
endpackage

// File: rtl/core/aes128_cfb8_stream_cipher_unit.sv
// AES-128 CFB8 stream cipher top level: control sequencer, round unit, memories.
// Depends on aes_pkg and aes_ram.
//
// One byte per item. When enabled, each item passes in order through a read
// of the direction's 128-bit shift register and the first round-key word from
// memory, round-key reads, one word per cycle from the 44-word round-key RAM,
// feeding one round unit that applies a round once four key words are held
// (initial add, nine full rounds, final round), a write-back step and a step
// to present the result. The next item is taken once the result is taken.
// While disabled, an item's byte is presented the cycle after it is accepted.
// Writing 1 to cipher_enable while idle starts a key expansion (both shift
// entries loaded with the key, then one round-key word per cycle), during
// which no item is taken.
module aes128_cfb8_stream_cipher_unit #(
  parameter int ROUND_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // command
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // result_byte
  output logic        out_tlast
);
  import aes_pkg::*;

  localparam int NW = 4 * (ROUND_COUNT + 1);
  localparam int AW = $clog2(NW);

  typedef enum logic [2:0] {S_IDLE, S_EXP, S_RDSR, S_ROUND, S_WB, S_OUT} st_t;

  st_t st_r;
  logic [63:0] kh_r, kl_r;
  logic en_r;
  logic [AW-1:0] cnt_r;
  logic [1:0] w_r;
  logic [3:0] rnd_r;
  logic [127:0] acc_r, kw_r, hist_r;
  logic [7:0] din_r, res_r;
  logic dec_r, eob_r, ov_r;
  logic [7:0] rc_r;

  // round key RAM
  logic rk_we;
  logic [AW-1:0] rk_wa, rk_ra;
  logic [31:0] rk_wd, rk_rd;
  aes_ram #(.WIDTH(32), .DEPTH(NW)) u_rk (
    .clk(clk), .we(rk_we), .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd));

  // shift register RAM: entry 0 encrypt, 1 decrypt
  logic sr_we, sr_wa, sr_ra;
  logic [127:0] sr_wd, sr_rd;
  aes_ram #(.WIDTH(128), .DEPTH(2)) u_sr (
    .clk(clk), .we(sr_we), .waddr(sr_wa), .wdata(sr_wd), .raddr(sr_ra), .rdata(sr_rd));

  logic [127:0] key;
  logic [31:0] tw, nw;
  assign key = {kh_r, kl_r};
  // expansion keeps last four words in hist_r
  always_comb begin
    tw = hist_r[31:0];
    if (cnt_r[1:0] == 2'd0) tw = sub_word({tw[23:0], tw[31:24]}) ^ {rc_r, 24'h0};
    nw = (cnt_r < AW'(4)) ? key[127 - 32*cnt_r[1:0] -: 32] : hist_r[127:96] ^ tw;
  end

  logic in_acc, cfg_en;
  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE) && !ov_r;
  assign cfg_en = cfg_we && cfg_index == CFG_ENABLE && cfg_wdata[0];

  always_comb begin
    rk_we = st_r == S_EXP;
    rk_wa = cnt_r;
    rk_wd = nw;
    rk_ra = (st_r == S_RDSR) ? AW'(0) : cnt_r;
    sr_ra = (st_r == S_IDLE) ? in_tuser : dec_r;
    sr_we = 1'b0;
    sr_wa = dec_r;
    sr_wd = {sr_rd[119:0], dec_r ? din_r : res_r};
    if (st_r == S_EXP && cnt_r == AW'(0)) begin
      sr_we = 1'b1;
      sr_wa = w_r[0];
      sr_wd = key;
    end else if (st_r == S_WB) begin
      sr_we = 1'b1;
    end
  end

  logic [127:0] rs;
  always_comb begin
    rs = acc_r;
    if (rnd_r != 4'd0) rs = sub_shift(rs);
    if (rnd_r != 4'd0 && rnd_r != 4'(ROUND_COUNT)) rs = mix(rs);
    rs = rs ^ kw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      kh_r <= '0;
      kl_r <= '0;
      en_r <= 1'b0;
      ov_r <= 1'b0;
      cnt_r <= '0;
      w_r <= '0;
    end else begin
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_HIGH: kh_r <= cfg_wdata;
          CFG_KEY_LOW:  kl_r <= cfg_wdata;
          CFG_ENABLE:   en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (cfg_en) begin
            st_r <= S_EXP;
            cnt_r <= '0;
            w_r <= 2'd0;
            rc_r <= 8'h01;
          end else if (in_acc) begin
            din_r <= in_tdata;
            dec_r <= in_tuser;
            eob_r <= in_tlast;
            if (en_r) st_r <= S_RDSR;
            else begin
              res_r <= in_tdata;
              ov_r <= 1'b1;
            end
          end
        end
        S_EXP: begin
          // second entry of the shift memory written on a follow-up cycle
          if (cnt_r == AW'(0) && w_r == 2'd0) w_r <= 2'd1;
          else begin
            w_r <= 2'd2;
            hist_r <= {hist_r[95:0], nw};
            if (cnt_r[1:0] == 2'd0 && cnt_r >= AW'(4)) rc_r <= xt(rc_r);
            if (cnt_r == AW'(NW - 1)) st_r <= S_IDLE;
            else cnt_r <= cnt_r + AW'(1);
          end
        end
        S_RDSR: begin
          // read shift entry and first key word
          cnt_r <= AW'(1);
          rnd_r <= 4'd0;
          st_r <= S_ROUND;
          w_r <= 2'd0;
        end
        S_ROUND: begin
          if (rnd_r == 4'd0 && w_r == 2'd0 && cnt_r == AW'(1)) acc_r <= sr_rd;
          kw_r <= {kw_r[95:0], rk_rd};
          w_r <= w_r + 2'd1;
          if (cnt_r != AW'(NW)) cnt_r <= (cnt_r == AW'(NW - 1)) ? cnt_r : cnt_r + AW'(1);
          if (w_r == 2'd3) begin
            // key words complete next cycle; apply round then
            rnd_r <= rnd_r;
          end
          if (w_r == 2'd0 && !(rnd_r == 4'd0 && cnt_r == AW'(1))) begin
            acc_r <= rs;
            if (rnd_r == 4'(ROUND_COUNT)) begin
              res_r <= din_r ^ rs[127:120];
              st_r <= S_WB;
            end else rnd_r <= rnd_r + 4'd1;
          end
        end
        S_WB: begin
          acc_r <= sr_rd;
          st_r <= S_OUT;
        end
        S_OUT: begin
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = res_r;
  assign out_tlast = eob_r;
endmodule

// File: rtl/core/aes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module aes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
